FILE: design/qtpp_pkg.sv
// Shared types, constants and datapath step functions for the quaternion
// to pointer position block. No dependencies.
package qtpp_pkg;

   // field and datapath widths
   localparam int QW         = 16;  // quaternion component, Q1.14
   localparam int PROD_W     = 32;  // component product, units of 2^-28
   localparam int SUM_W      = 34;  // doubled sum of two products
   localparam int S_W        = 30;  // clamped pitch sine
   localparam int SQ_W       = 58;  // square root radicand and work registers
   localparam int ROOT_W     = 29;  // square root result bits
   localparam int CW         = 40;  // rotation vector components
   localparam int ZW         = 22;  // binary angle accumulator
   localparam int TABLE_LEN  = 24;  // arctangent table entries
   localparam int ARM_W      = 15;
   localparam int SCR_W      = 12;
   localparam int SPAN_W     = 15;
   localparam int CUR_W      = 16;
   localparam int NUM_W      = 28;  // divider dividend and quotient
   localparam int REM_W      = 16;  // divider partial remainder
   localparam int UX_W       = 21;  // clamped yaw offset
   localparam int UY_W       = 20;  // clamped pitch offset
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   // angle and scaling constants (full circle is 2^20 units)
   localparam int TURN_BITS    = 20;
   localparam int HALF_TURN    = 524288;
   localparam int QUARTER_TURN = 262144;
   localparam int FULL_TURN    = 1048576;
   localparam int ARM_MAX      = 18432;
   localparam int HELD_RESET   = 1000;
   localparam int SCR_RESET_W  = 1366;
   localparam int SCR_RESET_H  = 768;

   localparam logic signed [SUM_W-1:0] ONE_Q  = SUM_W'(1 << 28);
   localparam logic [SQ_W-1:0]         SQ_ONE = SQ_W'(1) << (2 * (ROOT_W - 1));

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POINTER_ENABLE = 3'd0,
      CSR_SCREEN_WIDTH   = 3'd1,
      CSR_SCREEN_HEIGHT  = 3'd2,
      CSR_SPAN_X         = 3'd3,
      CSR_SPAN_Y         = 3'd4
   } csr_index_type;

   // square root stage: radicand remainder, partial root and passengers
   typedef struct packed {
      logic [SQ_W-1:0]         v;
      logic [SQ_W-1:0]         res;
      logic signed [S_W-1:0]   s;
      logic signed [SUM_W-1:0] ya;
      logic signed [SUM_W-1:0] xa;
   } root_type;

   // vectoring rotation lane
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 done;
   } lane_type;

   // restoring divider lane
   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [NUM_W-1:0] quo;
      logic [REM_W-1:0] rem;
   } div_type;

   // arctangent of 2^-i in angle units
   function automatic logic signed [ZW-1:0] atan_unit(input int i);
      logic signed [ZW-1:0] u;
      case (i)
         0:  u = ZW'(131072);
         1:  u = ZW'(77376);
         2:  u = ZW'(40884);
         3:  u = ZW'(20753);
         4:  u = ZW'(10417);
         5:  u = ZW'(5213);
         6:  u = ZW'(2607);
         7:  u = ZW'(1304);
         8:  u = ZW'(652);
         9:  u = ZW'(326);
         10: u = ZW'(163);
         11: u = ZW'(81);
         12: u = ZW'(41);
         13: u = ZW'(20);
         14: u = ZW'(10);
         15: u = ZW'(5);
         16: u = ZW'(3);
         17: u = ZW'(1);
         18: u = ZW'(1);
         default: u = '0;
      endcase
      return u;
   endfunction

   // one digit of the integer square root, trial weight 4^b
   function automatic root_type root_step(input root_type a, input int b);
      root_type        r;
      logic [SQ_W-1:0] bit_v;
      logic [SQ_W-1:0] trial;
      r     = a;
      bit_v = SQ_W'(1) << (2 * b);
      trial = a.res + bit_v;
      if (a.v >= trial) begin
         r.v   = a.v - trial;
         r.res = (a.res >> 1) + bit_v;
      end else begin
         r.res = a.res >> 1;
      end
      return r;
   endfunction

   // turn a left-half vector by half a circle; freeze on a zero y
   function automatic lane_type lane_pre(input logic signed [CW-1:0] x,
                                         input logic signed [CW-1:0] y);
      lane_type r;
      r.x = x;
      r.y = y;
      r.z = '0;
      if (x < 0) begin
         r.z = (y >= 0) ? ZW'(HALF_TURN) : -ZW'(HALF_TURN);
         r.x = -x;
         r.y = -y;
      end
      r.done = (r.y == 0);
      return r;
   endfunction

   // one micro-rotation driving y toward zero
   function automatic lane_type lane_step(input lane_type a, input int i);
      lane_type             r;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      r  = a;
      dx = a.y >>> i;
      dy = a.x >>> i;
      if (!a.done) begin
         if (a.y >= 0) begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + atan_unit(i);
         end else begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - atan_unit(i);
         end
      end
      return r;
   endfunction

   // one quotient bit of a restoring divide
   function automatic div_type div_step(input div_type a, input logic [SPAN_W-1:0] d,
                                        input int b);
      div_type          r;
      logic [REM_W-1:0] rs;
      r  = a;
      rs = {a.rem[REM_W-2:0], a.num[b]};
      if (rs >= REM_W'(d)) begin
         r.rem    = rs - REM_W'(d);
         r.quo[b] = 1'b1;
      end else begin
         r.rem = rs;
      end
      return r;
   endfunction

   // saturate a pointer coordinate to signed 16 bits
   function automatic logic signed [CUR_W-1:0] sat_cursor(
         input logic signed [NUM_W+1:0] v);
      logic signed [CUR_W-1:0] r;
      if (v > (NUM_W+2)'(32767)) begin
         r = CUR_W'(32767);
      end else if (v < -(NUM_W+2)'(32768)) begin
         r = CUR_W'(-32768);
      end else begin
         r = CUR_W'(v);
      end
      return r;
   endfunction

endpackage

FILE: design/quaternion_to_pointer_position.sv
// Top level: quaternion to arm position and screen pointer pipeline.
// Depends on qtpp_pkg for widths, register codes and step functions.
//
// Takes one Q1.14 quaternion per cycle while req_stall is low and returns one
// result per item, in order, through the product, sum and squaring stages,
// 29 square-root digit stages, one pre-rotation stage, one stage per angle
// micro-rotation, three scaling stages, 28 divider stages for the pointer
// mapping and the output register. Sustained rate is one item per clock while
// the result side does not stall. A skid register behind the output register
// absorbs one item when the result side stalls; the pipeline then freezes
// until it drains. Registers must be written through the csr_ port only while
// no item is in flight; the block itself does not enforce this.
module quaternion_to_pointer_position #(
   parameter int ANGLE_ITERATIONS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [qtpp_pkg::QW-1:0]       req_qw,
   input  logic signed [qtpp_pkg::QW-1:0]       req_qx,
   input  logic signed [qtpp_pkg::QW-1:0]       req_qy,
   input  logic signed [qtpp_pkg::QW-1:0]       req_qz,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [qtpp_pkg::ARM_W-1:0]           rsp_arm_x,
   output logic [qtpp_pkg::ARM_W-1:0]           rsp_arm_y,
   output logic signed [qtpp_pkg::CUR_W-1:0]    rsp_cursor_x,
   output logic signed [qtpp_pkg::CUR_W-1:0]    rsp_cursor_y,
   input  logic                                 csr_write_en,
   input  logic [qtpp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [qtpp_pkg::CSR_DATA_W-1:0]      csr_data
);
   import qtpp_pkg::*;

   // configuration registers
   logic              pointer_enable_ff;
   logic [SCR_W-1:0]  screen_width_ff;
   logic [SCR_W-1:0]  screen_height_ff;
   logic [SPAN_W-1:0] span_x_ff;
   logic [SPAN_W-1:0] span_y_ff;

   // pipeline control
   logic adv;
   logic skid_valid_ff;
   logic rsp_valid_ff;

   // product stage
   logic                     p1_valid_ff;
   logic signed [PROD_W-1:0] p1_wy_ff, p1_zx_ff, p1_wz_ff, p1_xy_ff, p1_yy_ff, p1_zz_ff;

   // sum stage
   logic                     p2_valid_ff;
   logic signed [S_W-1:0]    p2_s_ff;
   logic signed [SUM_W-1:0]  p2_ya_ff, p2_xa_ff;
   logic signed [SUM_W-1:0]  s_raw, s_clamp, ya_in, xa_in;

   // squaring and square root stages
   logic                rt_valid_ff [ROOT_W+1];
   root_type            rt_ff       [ROOT_W+1];
   logic [ROOT_W-1:0]   s_abs;
   logic [SQ_W-1:0]     s_sq;
   root_type            rt_in;

   // rotation stages
   logic     cv_valid_ff [ANGLE_ITERATIONS+1];
   lane_type cp_ff       [ANGLE_ITERATIONS+1];
   lane_type cy_ff       [ANGLE_ITERATIONS+1];

   // scaling stages
   logic                ux_valid_ff, arm_valid_ff;
   logic [UX_W-1:0]     ux_ff, ux_in;
   logic [UY_W-1:0]     uy_ff, uy_in;
   logic signed [ZW-1:0] yaw_off, pitch_off;
   logic [ARM_W-1:0]    arm_x_ff, arm_y_ff;
   logic [UX_W+ARM_W-1:0] prod_x;
   logic [UY_W+ARM_W-1:0] prod_y;

   // divider stages
   logic             dv_valid_ff [NUM_W+1];
   div_type          dx_ff       [NUM_W+1];
   div_type          dy_ff       [NUM_W+1];
   logic [ARM_W-1:0] dv_arm_x_ff [NUM_W+1];
   logic [ARM_W-1:0] dv_arm_y_ff [NUM_W+1];
   logic [SPAN_W-1:0] div_x, div_y;

   // final mapping, held pointer, output and skid
   logic signed [NUM_W+1:0] cx_full, cy_full;
   logic signed [CUR_W-1:0] cur_x, cur_y;
   logic signed [CUR_W-1:0] held_cursor_x_ff, held_cursor_y_ff;
   logic                    pipe_valid;
   logic                    out_free;
   logic [ARM_W-1:0]        rsp_arm_x_ff, rsp_arm_y_ff, skid_arm_x_ff, skid_arm_y_ff;
   logic signed [CUR_W-1:0] rsp_cursor_x_ff, rsp_cursor_y_ff;
   logic signed [CUR_W-1:0] skid_cursor_x_ff, skid_cursor_y_ff;

   // advance everything while the skid register is free
   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_enable_ff <= 1'b0;
         screen_width_ff   <= SCR_W'(SCR_RESET_W);
         screen_height_ff  <= SCR_W'(SCR_RESET_H);
         span_x_ff         <= SPAN_W'(ARM_MAX);
         span_y_ff         <= SPAN_W'(ARM_MAX);
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_POINTER_ENABLE: pointer_enable_ff <= csr_data[0];
            CSR_SCREEN_WIDTH:   screen_width_ff   <= csr_data[SCR_W-1:0];
            CSR_SCREEN_HEIGHT:  screen_height_ff  <= csr_data[SCR_W-1:0];
            CSR_SPAN_X:         span_x_ff         <= csr_data[SPAN_W-1:0];
            CSR_SPAN_Y:         span_y_ff         <= csr_data[SPAN_W-1:0];
            default: ;
         endcase
      end
   end

   // stage 1: component products
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_wy_ff <= req_qw * req_qy;
         p1_zx_ff <= req_qz * req_qx;
         p1_wz_ff <= req_qw * req_qz;
         p1_xy_ff <= req_qx * req_qy;
         p1_yy_ff <= req_qy * req_qy;
         p1_zz_ff <= req_qz * req_qz;
      end
   end

   // stage 2: clamped pitch sine and yaw vector
   always_comb begin
      s_raw = (SUM_W'(p1_wy_ff) - SUM_W'(p1_zx_ff)) <<< 1;
      if (s_raw > ONE_Q) begin
         s_clamp = ONE_Q;
      end else if (s_raw < -ONE_Q) begin
         s_clamp = -ONE_Q;
      end else begin
         s_clamp = s_raw;
      end
      ya_in = (SUM_W'(p1_wz_ff) + SUM_W'(p1_xy_ff)) <<< 1;
      xa_in = ONE_Q - ((SUM_W'(p1_yy_ff) + SUM_W'(p1_zz_ff)) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_s_ff  <= S_W'(s_clamp);
         p2_ya_ff <= ya_in;
         p2_xa_ff <= xa_in;
      end
   end

   // stage 3: radicand 1 - s^2 for the cosine
   always_comb begin
      s_abs    = ROOT_W'((p2_s_ff < 0) ? -p2_s_ff : p2_s_ff);
      s_sq     = SQ_W'(s_abs) * SQ_W'(s_abs);
      rt_in.v   = SQ_ONE - s_sq;
      rt_in.res = '0;
      rt_in.s   = p2_s_ff;
      rt_in.ya  = p2_ya_ff;
      rt_in.xa  = p2_xa_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         rt_valid_ff[0] <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rt_ff[0] <= rt_in;
      end
   end

   // square root, one root bit per stage from the top
   for (genvar k = 0; k < ROOT_W; k++) begin : g_root
      always_ff @(posedge clock) begin
         if (reset) begin
            rt_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            rt_valid_ff[k+1] <= rt_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rt_ff[k+1] <= root_step(rt_ff[k], ROOT_W - 1 - k);
         end
      end
   end

   // pre-rotation of both vectors
   always_ff @(posedge clock) begin
      if (reset) begin
         cv_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         cv_valid_ff[0] <= rt_valid_ff[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cp_ff[0] <= lane_pre($signed(CW'(rt_ff[ROOT_W].res[ROOT_W-1:0])),
                              CW'(rt_ff[ROOT_W].s));
         cy_ff[0] <= lane_pre(CW'(rt_ff[ROOT_W].xa), CW'(rt_ff[ROOT_W].ya));
      end
   end

   // micro-rotations, one per stage, pitch and yaw side by side
   for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (reset) begin
            cv_valid_ff[i+1] <= 1'b0;
         end else if (adv) begin
            cv_valid_ff[i+1] <= cv_valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cp_ff[i+1] <= lane_step(cp_ff[i], i);
            cy_ff[i+1] <= lane_step(cy_ff[i], i);
         end
      end
   end

   // offset and clamp the angles
   always_comb begin
      yaw_off   = cy_ff[ANGLE_ITERATIONS].z + ZW'(HALF_TURN);
      pitch_off = cp_ff[ANGLE_ITERATIONS].z + ZW'(QUARTER_TURN);
      if (yaw_off < 0) begin
         ux_in = '0;
      end else if (yaw_off > ZW'(FULL_TURN)) begin
         ux_in = UX_W'(FULL_TURN);
      end else begin
         ux_in = UX_W'(yaw_off);
      end
      if (pitch_off < 0) begin
         uy_in = '0;
      end else if (pitch_off > ZW'(HALF_TURN)) begin
         uy_in = UY_W'(HALF_TURN);
      end else begin
         uy_in = UY_W'(pitch_off);
      end
   end

   // scale to arm units
   assign prod_x = (UX_W+ARM_W)'(ux_ff) * (UX_W+ARM_W)'(ARM_MAX);
   assign prod_y = (UY_W+ARM_W)'(uy_ff) * (UY_W+ARM_W)'(ARM_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         ux_valid_ff  <= 1'b0;
         arm_valid_ff <= 1'b0;
      end else if (adv) begin
         ux_valid_ff  <= cv_valid_ff[ANGLE_ITERATIONS];
         arm_valid_ff <= ux_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ux_ff    <= ux_in;
         uy_ff    <= uy_in;
         arm_x_ff <= ARM_W'(prod_x >> TURN_BITS);
         arm_y_ff <= ARM_W'(prod_y >> (TURN_BITS - 1));
      end
   end

   // dividends 2*arm*screen; a zero span divides by one
   assign div_x = (span_x_ff == '0) ? SPAN_W'(1) : span_x_ff;
   assign div_y = (span_y_ff == '0) ? SPAN_W'(1) : span_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_valid_ff[0] <= arm_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff[0].num   <= NUM_W'({arm_x_ff, 1'b0}) * NUM_W'(screen_width_ff);
         dx_ff[0].quo   <= '0;
         dx_ff[0].rem   <= '0;
         dy_ff[0].num   <= NUM_W'({arm_y_ff, 1'b0}) * NUM_W'(screen_height_ff);
         dy_ff[0].quo   <= '0;
         dy_ff[0].rem   <= '0;
         dv_arm_x_ff[0] <= arm_x_ff;
         dv_arm_y_ff[0] <= arm_y_ff;
      end
   end

   // restoring divide, one quotient bit per stage
   for (genvar k = 0; k < NUM_W; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[k+1] <= dv_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dx_ff[k+1]       <= div_step(dx_ff[k], div_x, NUM_W - 1 - k);
            dy_ff[k+1]       <= div_step(dy_ff[k], div_y, NUM_W - 1 - k);
            dv_arm_x_ff[k+1] <= dv_arm_x_ff[k];
            dv_arm_y_ff[k+1] <= dv_arm_y_ff[k];
         end
      end
   end

   // pointer = 2*screen - quotient, or the held pointer when disabled
   always_comb begin
      cx_full = $signed((NUM_W+2)'({screen_width_ff, 1'b0}))
              - $signed((NUM_W+2)'(dx_ff[NUM_W].quo));
      cy_full = $signed((NUM_W+2)'({screen_height_ff, 1'b0}))
              - $signed((NUM_W+2)'(dy_ff[NUM_W].quo));
      cur_x   = pointer_enable_ff ? sat_cursor(cx_full) : held_cursor_x_ff;
      cur_y   = pointer_enable_ff ? sat_cursor(cy_full) : held_cursor_y_ff;
   end

   assign pipe_valid = dv_valid_ff[NUM_W];
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // output register, skid register and held pointer control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
         held_cursor_x_ff <= CUR_W'(HELD_RESET);
         held_cursor_y_ff <= CUR_W'(HELD_RESET);
      end else begin
         if (out_free) begin
            rsp_valid_ff  <= skid_valid_ff || pipe_valid;
            skid_valid_ff <= 1'b0;
         end else if (pipe_valid && adv) begin
            skid_valid_ff <= 1'b1;
         end
         if (pipe_valid && adv) begin
            held_cursor_x_ff <= cur_x;
            held_cursor_y_ff <= cur_y;
         end
      end
   end

   // output and skid payload
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_arm_x_ff    <= skid_arm_x_ff;
            rsp_arm_y_ff    <= skid_arm_y_ff;
            rsp_cursor_x_ff <= skid_cursor_x_ff;
            rsp_cursor_y_ff <= skid_cursor_y_ff;
         end else begin
            rsp_arm_x_ff    <= dv_arm_x_ff[NUM_W];
            rsp_arm_y_ff    <= dv_arm_y_ff[NUM_W];
            rsp_cursor_x_ff <= cur_x;
            rsp_cursor_y_ff <= cur_y;
         end
      end else if (pipe_valid && adv) begin
         skid_arm_x_ff    <= dv_arm_x_ff[NUM_W];
         skid_arm_y_ff    <= dv_arm_y_ff[NUM_W];
         skid_cursor_x_ff <= cur_x;
         skid_cursor_y_ff <= cur_y;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_arm_x    = rsp_arm_x_ff;
   assign rsp_arm_y    = rsp_arm_y_ff;
   assign rsp_cursor_x = rsp_cursor_x_ff;
   assign rsp_cursor_y = rsp_cursor_y_ff;

   // skid holds an item only behind a waiting output item
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full with empty output register");

   // skid fills only when the output was stalled
   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid register filled without a stalled output");

   // arm positions stay within 0..18432
   a_arm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_arm_x_ff <= ARM_W'(ARM_MAX)) && (rsp_arm_y_ff <= ARM_W'(ARM_MAX)))
      else $error("arm position out of range");

   // held pointer does not move while the pointer is disabled
   a_held_stable: assert property (@(posedge clock) disable iff (reset)
      !pointer_enable_ff |=> $stable(held_cursor_x_ff) && $stable(held_cursor_y_ff))
      else $error("held pointer changed while disabled");

endmodule

FILE: bench/tb_quaternion_to_pointer_position.sv
// Self-checking bench for quaternion_to_pointer_position: random and directed
// quaternions through valid/stall handshakes, compared with an in-bench predictor.
// Depends on qtpp_pkg and the quaternion_to_pointer_position RTL.
module tb_quaternion_to_pointer_position;
   timeunit 1ns;
   timeprecision 1ps;
   import qtpp_pkg::*;

   localparam int ITERS = 16;
   localparam int LATENCY = 65 + ITERS;
   localparam logic [CSR_IDX_W-1:0] UNUSED_INDEX = 3'd7;

   typedef struct {
      logic [ARM_W-1:0]        arm_x;
      logic [ARM_W-1:0]        arm_y;
      logic signed [CUR_W-1:0] cursor_x;
      logic signed [CUR_W-1:0] cursor_y;
   } pose_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [QW-1:0] req_qw = '0, req_qx = '0, req_qy = '0, req_qz = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ARM_W-1:0] rsp_arm_x, rsp_arm_y;
   logic signed [CUR_W-1:0] rsp_cursor_x, rsp_cursor_y;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   pose_type expected_poses[$];
   int errors = 0;
   bit hold_off = 0;
   int hold_cycles = 0;

   // predictor copy of the registers and held pointer
   bit          pred_enable = 0;
   int unsigned pred_scr_w = SCR_RESET_W, pred_scr_h = SCR_RESET_H;
   int unsigned pred_span_x = ARM_MAX, pred_span_y = ARM_MAX;
   longint      pred_held_x = HELD_RESET, pred_held_y = HELD_RESET;

   quaternion_to_pointer_position #(.ANGLE_ITERATIONS(ITERS)) DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("quaternion_to_pointer_position test failed");
      $finish;
   end

   function automatic longint atan_entry(int i);
      longint t[TABLE_LEN] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                               652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0, 0, 0, 0, 0};
      return t[i];
   endfunction

   function automatic longint floor_shr(longint v, int n);
      return v >>> n;
   endfunction

   // binary-angle atan2 by vectoring rotations
   function automatic longint vector_angle(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      if (x < 0) begin
         z = (y >= 0) ? HALF_TURN : -HALF_TURN;
         x = -x;
         y = -y;
      end
      if (y == 0) return z;
      for (int i = 0; i < ITERS && i < TABLE_LEN; i++) begin
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; z += atan_entry(i);
         end else begin
            x -= dx; y += dy; z -= atan_entry(i);
         end
      end
      return z;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint screen_pointer(longint arm, longint scr, longint span);
      longint sp;
      sp = span != 0 ? span : 1;
      return clamp(2 * scr - (2 * arm * scr) / sp, -32768, 32767);
   endfunction

   // predict arm position and pointer for one quaternion
   function automatic pose_type predict_pose(longint w, longint x, longint y, longint z);
      pose_type p;
      longint one, s, c, pitch, yaw, ux, uy, ax, ay;
      one = 64'sd1 << 28;
      s = clamp(2 * (w * y - z * x), -one, one);
      c = longint'(floor_sqrt(longint'(one * one) - s * s));
      pitch = vector_angle(s, c);
      yaw = vector_angle(2 * (w * z + x * y), one - 2 * (y * y + z * z));
      ux = clamp(yaw + HALF_TURN, 0, FULL_TURN);
      uy = clamp(pitch + QUARTER_TURN, 0, HALF_TURN);
      ax = (ux * ARM_MAX) >>> 20;
      ay = (uy * ARM_MAX) >>> 19;
      if (pred_enable) begin
         pred_held_x = screen_pointer(ax, pred_scr_w, pred_span_x);
         pred_held_y = screen_pointer(ay, pred_scr_h, pred_span_y);
      end
      p.arm_x = ARM_W'(ax);
      p.arm_y = ARM_W'(ay);
      p.cursor_x = CUR_W'(pred_held_x);
      p.cursor_y = CUR_W'(pred_held_y);
      return p;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
   endtask

   // send one quaternion after a random gap (none when no_gap is set), predicting
   // at acceptance; valid stays high between items sent back to back
   task automatic send_quat(logic signed [QW-1:0] w, x, y, z, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 9);
      if (($urandom & 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_qw <= w; req_qx <= x; req_qy <= y; req_qz <= z;
      do @(posedge clock); while (req_stall);
      expected_poses = {expected_poses, predict_pose(w, x, y, z)};
   endtask

   // drop valid and wait until every item is out
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_poses.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_POINTER_ENABLE: pred_enable = value[0];
         CSR_SCREEN_WIDTH:   pred_scr_w = value & 12'hFFF;
         CSR_SCREEN_HEIGHT:  pred_scr_h = value & 12'hFFF;
         CSR_SPAN_X:         pred_span_x = value & 15'h7FFF;
         CSR_SPAN_Y:         pred_span_y = value & 15'h7FFF;
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic signed [QW-1:0] rand_comp();
      return QW'($urandom_range(0, 32768) - 16384);
   endfunction

   // send a unit quaternion (normalized random direction), mostly
   task automatic send_random_quat();
      real a, b, c, d, n;
      if ($urandom_range(0, 9) < 2) begin
         send_quat(QW'($urandom), QW'($urandom), QW'($urandom), QW'($urandom));
      end else if ($urandom_range(0, 9) < 2) begin
         send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end else begin
         a = $urandom_range(0, 2000) - 1000.0; b = $urandom_range(0, 2000) - 1000.0;
         c = $urandom_range(0, 2000) - 1000.0; d = $urandom_range(0, 2000) - 1000.0;
         n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
         send_quat(QW'($rtoi(a / n * 16384)), QW'($rtoi(b / n * 16384)),
                   QW'($rtoi(c / n * 16384)), QW'($rtoi(d / n * 16384)));
      end
   endtask

   // receiver stall: random per item, or a long hold-off on request
   initial begin
      int wait_n;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            hold_cycles++;
            if (hold_cycles >= 200) hold_off = 0;
         end else if (rsp_valid && !rsp_stall) begin
            wait_n = ($urandom & 3) == 0 ? 0 : $urandom_range(0, 9);
            if (wait_n > 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_n) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // check each accepted result against the oldest prediction
   initial begin
      pose_type e;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_poses.size() == 0) begin
               report_mismatch("unexpected item", 0, 0);
            end else begin
               e = expected_poses.pop_front();
               if (rsp_arm_x !== e.arm_x) report_mismatch("arm_x", rsp_arm_x, e.arm_x);
               if (rsp_arm_y !== e.arm_y) report_mismatch("arm_y", rsp_arm_y, e.arm_y);
               if (rsp_cursor_x !== e.cursor_x)
                  report_mismatch("cursor_x", rsp_cursor_x, e.cursor_x);
               if (rsp_cursor_y !== e.cursor_y)
                  report_mismatch("cursor_y", rsp_cursor_y, e.cursor_y);
            end
         end
      end
   end

   task automatic test_directed();
      send_quat(16384, 0, 0, 0);
      send_quat(-16384, 0, 0, 0);
      send_quat(0, 16384, 0, 0);
      send_quat(0, 0, 16384, 0);
      send_quat(0, 0, 0, 16384);
      send_quat(0, 0, 0, -16384);
      send_quat(0, 0, 0, 0);
      send_quat(11585, 0, 11585, 0);
      send_quat(11585, 0, -11585, 0);
      send_quat(11585, 0, 0, 11585);
      send_quat(11585, 0, 0, -11585);
      send_quat(-16384, -16384, -16384, -16384);
      send_quat(16384, 16384, 16384, 16384);
      send_quat(-32768, 32767, -32768, 32767);
      send_quat(32767, -32768, 32767, -32768);
      send_quat(0, -16384, 0, 0);
      drain_results();
   endtask

   task automatic test_pointer_settings();
      write_reg(CSR_POINTER_ENABLE, 1);
      repeat (60) send_random_quat();
      drain_results();
      write_reg(CSR_SCREEN_WIDTH, 4095);
      write_reg(CSR_SCREEN_HEIGHT, 1);
      write_reg(CSR_SPAN_X, 1);
      write_reg(CSR_SPAN_Y, 18432);
      repeat (60) send_random_quat();
      drain_results();
      write_reg(CSR_SCREEN_WIDTH, 0);
      write_reg(CSR_SCREEN_HEIGHT, 4095);
      write_reg(CSR_SPAN_X, 0);
      write_reg(CSR_SPAN_Y, 32767);
      repeat (60) send_random_quat();
      drain_results();
      write_reg(CSR_POINTER_ENABLE, 0);
      write_reg(CSR_SCREEN_WIDTH, 800);
      repeat (60) send_random_quat();
      drain_results();
      // unknown index must be ignored
      csr_write_en <= 1'b1;
      csr_index <= UNUSED_INDEX;
      csr_data <= '1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      write_reg(CSR_POINTER_ENABLE, 1);
      write_reg(CSR_SPAN_X, 9000);
      write_reg(CSR_SPAN_Y, 5000);
      write_reg(CSR_SCREEN_HEIGHT, 1080);
   endtask

   task automatic test_backpressure();
      hold_cycles = 0;
      hold_off = 1;
      repeat (150) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp(), 1);
      drain_results();
   endtask

   task automatic test_random();
      repeat (500) send_random_quat();
      drain_results();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_pointer_settings();
      test_backpressure();
      test_random();
      if (errors == 0) begin
         $display("quaternion_to_pointer_position test passed");
      end else begin
         $display("quaternion_to_pointer_position test failed");
      end
      $finish;
   end
endmodule

FILE: quaternion_to_pointer_position.f
design/qtpp_pkg.sv
design/quaternion_to_pointer_position.sv
bench/tb_quaternion_to_pointer_position.sv
